/* design/hmp_pkg.sv */
package hmp_pkg;

   localparam int CAPACITY      = 128;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = IDX_W + 1;
   localparam int KEY_W         = 32;
   localparam int CMD_W         = 2;
   localparam int POS_W         = 7;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 8;

   localparam logic signed [KEY_W-1:0] DEL_SENTINEL = 32'sh8000_0001;
   localparam logic signed [KEY_W-1:0] EMPTY_VALUE  = -32'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_DELETE  = 2'd1,
      CMD_EXTRACT = 2'd2
   } hmp_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_BAD_POS = 2'd3
   } hmp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_EX_READ,
      S_EX_LOAD,
      S_DN_READ,
      S_DN_SEL,
      S_DN_SWAP,
      S_DONE
   } hmp_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        position;
   } hmp_req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   min_value;
      logic [STATUS_W-1:0]       status;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } hmp_rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]        rd_a_addr;
      logic [IDX_W-1:0]        rd_b_addr;
      logic                    wr_en;
      logic [IDX_W-1:0]        wr_addr;
      logic signed [KEY_W-1:0] wr_data;
   } hmp_mem_req_type;

endpackage

/* design/hmp_if.sv */
interface hmp_req_if import hmp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [KEY_W-1:0] key;
   logic [POS_W-1:0]        position;

   modport source (output valid, command, key, position, input ready);
   modport sink (input valid, command, key, position, output ready);
endinterface

interface hmp_rsp_if import hmp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [KEY_W-1:0]  min_value;
   logic [STATUS_W-1:0]      status;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (output valid, min_value, status, entry_count, input ready);
   modport sink (input valid, min_value, status, entry_count, output ready);
endinterface

/* design/hmp_store.sv */
module hmp_store import hmp_pkg::*; (
   input  logic                    clock,
   input  hmp_mem_req_type         mem_req,
   output logic signed [KEY_W-1:0] rd_a,
   output logic signed [KEY_W-1:0] rd_b
);

   logic signed [KEY_W-1:0] mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_a_ff;
   logic signed [KEY_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_a_ff <= mem[mem_req.rd_a_addr];
      rd_b_ff <= mem[mem_req.rd_b_addr];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

/* design/hmp_seq.sv */
module hmp_seq import hmp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  hmp_req_type             req,
   output logic                    idle,
   input  logic                    rsp_free,
   output logic                    done,
   output hmp_rsp_type             result,
   output hmp_mem_req_type         mem_req,
   input  logic signed [KEY_W-1:0] rd_a,
   input  logic signed [KEY_W-1:0] rd_b
);

   hmp_state_type           state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   hmp_status_type          status_ff, status_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        child_idx_ff, child_idx_in;
   logic signed [KEY_W-1:0] cur_ff, cur_in;
   logic signed [KEY_W-1:0] top_ff, top_in;
   logic signed [KEY_W-1:0] child_ff, child_in;

   logic signed [KEY_W-1:0] cmp_a;
   logic signed [KEY_W-1:0] cmp_b;
   logic                    lt;
   logic [IDX_W-1:0]        parent;
   logic [CNT_W-1:0]        left;
   logic [CNT_W-1:0]        right;
   logic                    right_valid;
   logic                    sel_right;
   logic                    is_delete;

   assign parent      = IDX_W'((idx_ff - 1'b1) >> 1);
   assign left        = {idx_ff, 1'b1};
   assign right       = left + 1'b1;
   assign right_valid = right < count_ff;
   assign sel_right   = right_valid && lt;
   assign is_delete   = cmd_ff == CMD_DELETE;

   // The single comparator is shared by both sift directions.
   always_comb begin
      cmp_a = cur_ff;
      cmp_b = rd_a;
      unique case (state_ff)
         S_DN_SEL: begin
            cmp_a = rd_b;
            cmp_b = rd_a;
         end
         S_DN_SWAP: begin
            cmp_a = child_ff;
            cmp_b = cur_ff;
         end
         default: begin
            cmp_a = cur_ff;
            cmp_b = rd_a;
         end
      endcase
   end

   assign lt = cmp_a < cmp_b;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req.command)
                  CMD_INSERT: begin
                     state_in = (count_ff == CNT_W'(CAPACITY)) ? S_DONE : S_UP_READ;
                  end
                  CMD_DELETE: begin
                     state_in = (CNT_W'(req.position) < count_ff) ? S_UP_READ : S_DONE;
                  end
                  CMD_EXTRACT: begin
                     state_in = (count_ff == '0) ? S_DONE : S_EX_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UP_READ: begin
            if (idx_ff == '0) begin
               state_in = is_delete ? S_EX_READ : S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (lt) begin
               state_in = S_UP_READ;
            end else begin
               state_in = is_delete ? S_EX_READ : S_DONE;
            end
         end
         S_EX_READ: begin
            state_in = S_EX_LOAD;
         end
         S_EX_LOAD: begin
            state_in = (count_ff == CNT_W'(1)) ? S_DONE : S_DN_READ;
         end
         S_DN_READ: begin
            state_in = (left >= count_ff) ? S_DONE : S_DN_SEL;
         end
         S_DN_SEL: begin
            state_in = S_DN_SWAP;
         end
         S_DN_SWAP: begin
            state_in = lt ? S_DN_READ : S_DONE;
         end
         S_DONE: begin
            state_in = rsp_free ? S_IDLE : S_DONE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_req.rd_a_addr = parent;
      mem_req.rd_b_addr = IDX_W'(right);
      mem_req.wr_en     = 1'b0;
      mem_req.wr_addr   = idx_ff;
      mem_req.wr_data   = cur_ff;
      idle              = 1'b0;
      done              = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
         end
         S_UP_READ: begin
            mem_req.rd_a_addr = parent;
            mem_req.wr_en     = idx_ff == '0;
         end
         S_UP_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = lt ? rd_a : cur_ff;
         end
         S_EX_READ: begin
            mem_req.rd_a_addr = '0;
            mem_req.rd_b_addr = IDX_W'(count_ff - 1'b1);
         end
         S_DN_READ: begin
            mem_req.rd_a_addr = IDX_W'(left);
            mem_req.rd_b_addr = IDX_W'(right);
            mem_req.wr_en     = left >= count_ff;
         end
         S_DN_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = lt ? child_ff : cur_ff;
         end
         S_DONE: begin
            done = rsp_free;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      child_idx_in = child_idx_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      child_in     = child_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req.command;
               status_in = STATUS_OK;
               top_in    = '0;
               case (req.command)
                  CMD_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        idx_in   = IDX_W'(count_ff);
                        cur_in   = req.key;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (CNT_W'(req.position) < count_ff) begin
                        idx_in = IDX_W'(req.position);
                        cur_in = DEL_SENTINEL;
                     end else begin
                        status_in = STATUS_BAD_POS;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        top_in    = EMPTY_VALUE;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_UP_CMP: begin
            if (lt) begin
               idx_in = parent;
            end
         end
         S_EX_LOAD: begin
            top_in   = rd_a;
            cur_in   = rd_b;
            count_in = count_ff - 1'b1;
            idx_in   = '0;
         end
         S_DN_SEL: begin
            child_in     = sel_right ? rd_b : rd_a;
            child_idx_in = sel_right ? IDX_W'(right) : IDX_W'(left);
         end
         S_DN_SWAP: begin
            if (lt) begin
               idx_in = child_idx_ff;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      child_idx_ff <= child_idx_in;
      cur_ff       <= cur_in;
      top_ff       <= top_in;
      child_ff     <= child_in;
   end

   assign result.min_value   = (cmd_ff == CMD_EXTRACT) ? top_ff : '0;
   assign result.status      = status_ff;
   assign result.entry_count = ENTRY_COUNT_W'(count_ff);

endmodule

/* design/binary_min_heap_engine_core.sv */
// Binary min-heap of 128 signed 32-bit keys, one command per transaction: insert a key,
// delete the entry at an array position, or extract the minimum; every command returns one
// result with the extracted value, a status and the entry count afterwards. One comparator
// and one store with two read ports and one write port are stepped by a sequencer, and the
// request side is not ready while a command is in progress. Each sift-up level is a read
// step and a compare-and-write step, each sift-down level a read, a select and a swap step,
// and a delete runs a sift-up followed by an extract. The sequencer returns to idle, ready
// for the next request, at the edge that registers the result, and a finished command holds
// the sequencer while the response register is full and not being read. A finished result
// waits in the response register while the next request is taken.
module binary_min_heap_engine_core import hmp_pkg::*; (
   input logic      clock,
   input logic      reset,
   hmp_req_if.sink  req_if,
   hmp_rsp_if.source rsp_if
);

   hmp_req_type             req;
   hmp_rsp_type             result;
   hmp_mem_req_type         mem_req;
   logic signed [KEY_W-1:0] rd_a;
   logic signed [KEY_W-1:0] rd_b;
   logic                    idle;
   logic                    start;
   logic                    done;
   logic                    rsp_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   hmp_rsp_type             rsp_data_ff, rsp_data_in;

   assign req.command  = req_if.command;
   assign req.key      = req_if.key;
   assign req.position = req_if.position;

   assign req_if.ready = idle;
   assign start        = req_if.valid && idle;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   hmp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .idle     (idle),
      .rsp_free (rsp_free),
      .done     (done),
      .result   (result),
      .mem_req  (mem_req),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   hmp_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.min_value   = rsp_data_ff.min_value;
   assign rsp_if.status      = rsp_data_ff.status;
   assign rsp_if.entry_count = rsp_data_ff.entry_count;

endmodule

/* bench/heap_checker.sv */
module heap_checker import hmp_pkg::*; (
   input  logic clock,
   input  logic reset,
   hmp_req_if   req_mon,
   hmp_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [KEY_W-1:0] heap_keys [CAPACITY];
   int                      live_count;
   hmp_rsp_type             results_due [$];

   function automatic void heap_swap(int a, int b);
      logic signed [KEY_W-1:0] held;
      held         = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = held;
   endfunction

   function automatic void heap_sift_up(int idx);
      int parent;
      while (idx > 0) begin
         parent = (idx - 1) / 2;
         if (!(heap_keys[idx] < heap_keys[parent])) break;
         heap_swap(idx, parent);
         idx = parent;
      end
   endfunction

   function automatic void heap_sift_down(int idx);
      int left;
      int right;
      int best;
      forever begin
         left  = 2 * idx + 1;
         right = left + 1;
         best  = idx;
         if (left >= live_count) break;
         if (heap_keys[left] < heap_keys[best]) best = left;
         if (right < live_count && heap_keys[right] < heap_keys[best]) best = right;
         if (best == idx) break;
         heap_swap(idx, best);
         idx = best;
      end
   endfunction

   function automatic logic signed [KEY_W-1:0] heap_take_root();
      logic signed [KEY_W-1:0] root;
      root                  = heap_keys[0];
      live_count            = live_count - 1;
      heap_keys[0]          = heap_keys[live_count];
      heap_keys[live_count] = root;
      heap_sift_down(0);
      return root;
   endfunction

   function automatic hmp_rsp_type heap_command(hmp_req_type cmd_in);
      hmp_rsp_type outcome;
      outcome.min_value = '0;
      outcome.status    = STATUS_OK;
      case (cmd_in.command)
         CMD_INSERT: begin
            if (live_count < CAPACITY) begin
               heap_keys[live_count] = cmd_in.key;
               heap_sift_up(live_count);
               live_count = live_count + 1;
            end else begin
               outcome.status = STATUS_FULL;
            end
         end
         CMD_DELETE: begin
            if (int'(cmd_in.position) < live_count) begin
               heap_keys[cmd_in.position] = DEL_SENTINEL;
               heap_sift_up(int'(cmd_in.position));
               void'(heap_take_root());
            end else begin
               outcome.status = STATUS_BAD_POS;
            end
         end
         CMD_EXTRACT: begin
            if (live_count == 0) begin
               outcome.min_value = EMPTY_VALUE;
               outcome.status    = STATUS_EMPTY;
            end else begin
               outcome.min_value = heap_take_root();
            end
         end
         default: begin
         end
      endcase
      outcome.entry_count = ENTRY_COUNT_W'(live_count);
      return outcome;
   endfunction

   // The response side of an edge is handled first, so that a result arriving
   // with nothing outstanding is never matched to a transaction taken at the same edge.
   always @(posedge clock) begin
      hmp_req_type cmd_in;
      hmp_rsp_type due;
      if (reset) begin
         live_count  = 0;
         error_count = 0;
         results_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (results_due.size() == 0) begin
               $error("unexpected result: min_value %0d status %0d entry_count %0d",
                      rsp_mon.min_value, rsp_mon.status, rsp_mon.entry_count);
               error_count++;
            end else begin
               due = results_due.pop_front();
               if (rsp_mon.min_value !== due.min_value) begin
                  $error("min_value mismatch: expected %0d, actual %0d",
                         due.min_value, rsp_mon.min_value);
                  error_count++;
               end
               if (rsp_mon.status !== due.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         due.status, rsp_mon.status);
                  error_count++;
               end
               if (rsp_mon.entry_count !== due.entry_count) begin
                  $error("entry_count mismatch: expected %0d, actual %0d",
                         due.entry_count, rsp_mon.entry_count);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            cmd_in.command  = req_mon.command;
            cmd_in.key      = req_mon.key;
            cmd_in.position = req_mon.position;
            results_due.push_back(heap_command(cmd_in));
         end
      end
      pending_count = results_due.size();
   end

endmodule

/* bench/tb_top.sv */
module tb_top import hmp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [KEY_W-1:0] KEY_FLOOR = DEL_SENTINEL + 1;
   localparam logic signed [KEY_W-1:0] KEY_CEIL  = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pending_count;
   int   sent_count;

   hmp_req_if req_chan ();
   hmp_rsp_if rsp_chan ();

   binary_min_heap_engine_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   heap_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #6ns clock = ~clock;

   function automatic logic signed [KEY_W-1:0] random_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = $signed($urandom_range(0, 16)) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: k = KEY_CEIL;
               1: k = KEY_FLOOR;
               2: k = '0;
               default: k = -1;
            endcase
         end
         default: k = $urandom;
      endcase
      if (k < KEY_FLOOR) k = KEY_FLOOR;
      return k;
   endfunction

   function automatic logic [POS_W-1:0] random_position();
      if ($urandom_range(0, 1) == 1) return POS_W'($urandom_range(0, 15));
      return POS_W'($urandom_range(0, 127));
   endfunction

   task automatic send_item(hmp_cmd_type cmd, logic signed [KEY_W-1:0] key_val,
                            logic [POS_W-1:0] pos);
      int gap;
      gap = (((sent_count / 64) % 4) == 3) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= cmd;
      req_chan.key      <= key_val;
      req_chan.position <= pos;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic run_phase(int count, int insert_pct, int extract_pct);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < insert_pct)
            send_item(CMD_INSERT, random_key(), random_position());
         else if (roll < insert_pct + extract_pct)
            send_item(CMD_EXTRACT, random_key(), random_position());
         else
            send_item(CMD_DELETE, random_key(), random_position());
      end
   endtask

   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = (((taken / 64) % 4) == 2) ? 0 : $urandom_range(0, 14);
         if (taken == 150 || taken == 700) stall = 400;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      #5ms;
      $display("binary_min_heap_engine_core verification failed");
      $finish;
   end

   initial begin
      sent_count        = 0;
      req_chan.valid    = 1'b0;
      req_chan.command  = CMD_INSERT;
      req_chan.key      = '0;
      req_chan.position = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(CMD_EXTRACT, random_key(), random_position());
      send_item(CMD_DELETE, random_key(), 7'd0);
      send_item(CMD_DELETE, random_key(), 7'd127);
      send_item(CMD_INSERT, KEY_CEIL, 7'd127);
      send_item(CMD_INSERT, KEY_FLOOR, 7'd0);
      send_item(CMD_INSERT, 32'sd0, random_position());
      send_item(CMD_INSERT, -32'sd1, random_position());
      send_item(CMD_INSERT, 32'sd5, random_position());
      send_item(CMD_INSERT, 32'sd5, random_position());
      send_item(CMD_INSERT, 32'sd3, random_position());
      send_item(CMD_INSERT, 32'sd5, random_position());
      send_item(CMD_DELETE, random_key(), 7'd6);
      send_item(CMD_DELETE, random_key(), 7'd6);
      send_item(CMD_DELETE, random_key(), 7'd0);
      send_item(CMD_DELETE, random_key(), 7'd2);
      repeat (5) send_item(CMD_EXTRACT, random_key(), random_position());
      wait_drained();

      run_phase(200, 88, 6);
      run_phase(150, 45, 35);
      wait_drained();
      run_phase(200, 8, 60);
      run_phase(200, 88, 6);
      run_phase(220, 8, 60);
      run_phase(180, 45, 35);

      wait_drained();
      repeat (60) @(negedge clock);
      if (error_count == 0) begin
         $display("binary_min_heap_engine_core verification clean");
      end else begin
         $display("binary_min_heap_engine_core verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/hmp_pkg.sv
design/hmp_if.sv
design/hmp_store.sv
design/hmp_seq.sv
design/binary_min_heap_engine_core.sv
bench/heap_checker.sv
bench/tb_top.sv
